// File: hdl/hsd_pkg.sv
package hsd_pkg;

  localparam int NODE_DEPTH = 512;
  localparam int STACK_DEPTH = 256;
  localparam int NODE_AW = $clog2(NODE_DEPTH);
  localparam int NODE_CW = $clog2(NODE_DEPTH + 1);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int STACK_LW = $clog2(STACK_DEPTH + 1);
  localparam int TREE_LW = 13;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ESC = 8'h5C;

  typedef enum logic [1:0] {
    PH_HDR1,
    PH_HDR2,
    PH_TREE,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STK,
    S_PAR,
    S_WALK,
    S_POST
  } fsm_t;

  typedef enum logic [1:0] {
    RS_SYMBOL = 2'd0,
    RS_END = 2'd1,
    RS_FAULT = 2'd2
  } status_t;

  typedef struct packed {
    logic leaf;
    logic [7:0] sym;
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
  } node_t;

  typedef struct packed {
    logic [7:0] symbol;
    status_t status;
  } result_t;

  typedef struct packed {
    logic push;
    logic flush;
    result_t res;
  } res_ctl_t;

  typedef struct packed {
    logic can_push;
    logic flush_ok;
  } res_sts_t;

endpackage

// File: hdl/hsd_if.sv
interface hsd_in_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;
  logic final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface hsd_out_if;
  logic valid;
  logic ready;
  logic [7:0] symbol;
  logic [1:0] status;
  logic run_last;

  modport source (output valid, output symbol, output status, output run_last, input ready);
  modport sink (input valid, input symbol, input status, input run_last, output ready);
endinterface

// File: hdl/hsd_result_q.sv
module hsd_result_q (
  input  logic              clk,
  input  logic              rst_n,
  input  hsd_pkg::res_ctl_t res_ctl,
  output hsd_pkg::res_sts_t res_sts,
  hsd_out_if.source         out_ch
);

  logic             hold_v_r;
  hsd_pkg::result_t hold_r;
  logic             out_v_r;
  hsd_pkg::result_t out_res_r;
  logic             out_last_r;
  logic             out_free;
  logic             do_push;
  logic             do_flush;

  assign out_free = !out_v_r || out_ch.ready;
  assign res_sts.can_push = !hold_v_r || out_free;
  assign res_sts.flush_ok = !hold_v_r || out_free;
  assign do_push = res_ctl.push && res_sts.can_push;
  assign do_flush = !res_ctl.push && res_ctl.flush && hold_v_r && out_free;

  // the newest result waits in the holding slot until it is known whether
  // another one from the same input byte follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      if ((do_push && hold_v_r) || do_flush) begin
        out_v_r <= 1'b1;
      end else if (out_free) begin
        out_v_r <= 1'b0;
      end
      if (do_push) begin
        hold_v_r <= 1'b1;
      end else if (do_flush) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      hold_r <= res_ctl.res;
      if (hold_v_r) begin
        out_res_r <= hold_r;
        out_last_r <= 1'b0;
      end
    end else if (do_flush) begin
      out_res_r <= hold_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.symbol = out_res_r.symbol;
  assign out_ch.status = out_res_r.status;
  assign out_ch.run_last = out_last_r;

endmodule

// File: hdl/huffman_stream_decoder.sv
// Channel  Direction  Payload                               Handshake
// in_ch    in         in_byte[7:0], final_byte              valid / ready
// out_ch   out        symbol[7:0], status[1:0], run_last    valid / ready
//
// Header byte: accept, close. Tree byte: accept, close; for a node with a parent, a stack
// read and a parent read-modify-write in the node store come between. Payload byte: accept,
// a walk step per unskipped code bit (a node-store read while the next node is inner),
// then close. A final byte adds a closing step per status result. Reset is synchronous;
// the node store and the stack have no reset and need no clearing pass. Results go
// through a holding slot and an output register; the walk halts while neither has room.
module huffman_stream_decoder (
  input  logic      clk,
  input  logic      rst_n,
  hsd_in_if.sink    in_ch,
  hsd_out_if.source out_ch
);

  hsd_pkg::fsm_t   state_r, state_nxt;
  hsd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]                     pad_r, pad_nxt;
  logic [hsd_pkg::TREE_LW-1:0]    tl_r, tl_nxt;
  logic                           esc_r, esc_nxt;
  logic [hsd_pkg::NODE_CW-1:0]    count_r, count_nxt;
  logic [hsd_pkg::STACK_LW-1:0]   level_r, level_nxt;
  logic                           fault_r, fault_nxt;
  hsd_pkg::node_t                 cur_r, cur_nxt;
  logic [7:0]                     byte_r, byte_nxt;
  logic                           fin_r, fin_nxt;
  logic [2:0]                     bit_r, bit_nxt;
  logic [2:0]                     lo_r, lo_nxt;
  logic [hsd_pkg::NODE_AW-1:0]    add_idx_r, add_idx_nxt;
  logic                           add_leaf_r, add_leaf_nxt;
  logic                           bad_r, bad_nxt;
  logic                           trunc_r, trunc_nxt;
  logic                           end_r, end_nxt;
  logic                           load_root_r, load_root_nxt;
  hsd_pkg::node_t                 root_r;

  hsd_pkg::node_t                 node_mem [hsd_pkg::NODE_DEPTH];
  hsd_pkg::node_t                 node_rd_r;
  logic                           node_we, node_re;
  logic [hsd_pkg::NODE_AW-1:0]    node_waddr, node_raddr;
  hsd_pkg::node_t                 node_wdata;

  logic [hsd_pkg::NODE_AW-1:0]    stk_mem [hsd_pkg::STACK_DEPTH];
  logic [hsd_pkg::NODE_AW-1:0]    stk_rd_r;
  logic                           stk_we, stk_re;
  logic [hsd_pkg::STACK_AW-1:0]   stk_waddr, stk_raddr;
  logic [hsd_pkg::NODE_AW-1:0]    stk_wdata;

  hsd_pkg::res_ctl_t              res_ctl;
  hsd_pkg::res_sts_t              res_sts;

  assign in_ch.ready = (state_r == hsd_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd_r <= node_mem[node_raddr];
    end
    // shadow of the root entry, so the walk restarts without a read
    if (node_we && node_waddr == '0) begin
      root_r <= node_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsd_pkg::S_IDLE;
      phase_r <= hsd_pkg::PH_HDR1;
      pad_r <= '0;
      tl_r <= '0;
      esc_r <= 1'b0;
      count_r <= '0;
      level_r <= '0;
      fault_r <= 1'b0;
      bad_r <= 1'b0;
      trunc_r <= 1'b0;
      end_r <= 1'b0;
      load_root_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pad_r <= pad_nxt;
      tl_r <= tl_nxt;
      esc_r <= esc_nxt;
      count_r <= count_nxt;
      level_r <= level_nxt;
      fault_r <= fault_nxt;
      bad_r <= bad_nxt;
      trunc_r <= trunc_nxt;
      end_r <= end_nxt;
      load_root_r <= load_root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    byte_r <= byte_nxt;
    fin_r <= fin_nxt;
    bit_r <= bit_nxt;
    lo_r <= lo_nxt;
    add_idx_r <= add_idx_nxt;
    add_leaf_r <= add_leaf_nxt;
  end

  always_comb begin
    logic [7:0]                   b;
    logic [hsd_pkg::TREE_LW-1:0]  tl_v;
    logic                         add_v;
    logic                         leaf_v;
    logic [7:0]                   sym_v;
    logic [hsd_pkg::STACK_LW-1:0] level_v;
    logic [hsd_pkg::STACK_LW-1:0] lvl_m1;
    logic [hsd_pkg::NODE_CW-1:0]  count_v;
    logic                         fin_v;
    logic                         go_post;
    logic                         bad_v;
    logic                         chk_v;
    logic [2:0]                   bit_v;
    logic                         emit_v;
    hsd_pkg::node_t               new_cur;
    hsd_pkg::node_t               p;

    state_nxt = state_r;
    phase_nxt = phase_r;
    pad_nxt = pad_r;
    tl_nxt = tl_r;
    esc_nxt = esc_r;
    count_nxt = count_r;
    level_nxt = level_r;
    fault_nxt = fault_r;
    cur_nxt = cur_r;
    byte_nxt = byte_r;
    fin_nxt = fin_r;
    bit_nxt = bit_r;
    lo_nxt = lo_r;
    add_idx_nxt = add_idx_r;
    add_leaf_nxt = add_leaf_r;
    bad_nxt = bad_r;
    trunc_nxt = trunc_r;
    end_nxt = end_r;
    load_root_nxt = load_root_r;

    node_we = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_re = 1'b0;
    node_raddr = '0;
    stk_we = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_re = 1'b0;
    stk_raddr = '0;

    res_ctl.push = 1'b0;
    res_ctl.flush = 1'b0;
    res_ctl.res.symbol = '0;
    res_ctl.res.status = hsd_pkg::RS_SYMBOL;

    b = in_ch.in_byte;
    tl_v = tl_r - hsd_pkg::TREE_LW'(1);
    add_v = 1'b0;
    leaf_v = 1'b1;
    sym_v = '0;
    level_v = level_r;
    lvl_m1 = level_r - hsd_pkg::STACK_LW'(1);
    count_v = count_r + hsd_pkg::NODE_CW'(1);
    fin_v = fin_r;
    go_post = 1'b0;
    bad_v = 1'b0;
    chk_v = 1'b0;
    bit_v = bit_r - 3'd1;
    emit_v = cur_r.leaf || node_rd_r.leaf;
    new_cur = emit_v ? root_r : node_rd_r;
    p = node_rd_r;

    unique case (state_r)
      hsd_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          fin_v = in_ch.final_byte;
          fin_nxt = in_ch.final_byte;
          if (fault_r) begin
            // drop bytes until the end of the file
            go_post = fin_v;
          end else begin
            unique case (phase_r)
              hsd_pkg::PH_HDR1: begin
                pad_nxt = b[7:5];
                tl_nxt = {b[4:0], 8'h00};
                phase_nxt = hsd_pkg::PH_HDR2;
                go_post = 1'b1;
              end
              hsd_pkg::PH_HDR2: begin
                tl_nxt = tl_r | {5'd0, b};
                if ((tl_r | {5'd0, b}) == '0) begin
                  bad_v = 1'b1;
                end else begin
                  phase_nxt = hsd_pkg::PH_TREE;
                end
                go_post = 1'b1;
              end
              hsd_pkg::PH_TREE: begin
                tl_nxt = tl_v;
                if (esc_r) begin
                  esc_nxt = 1'b0;
                  add_v = 1'b1;
                  sym_v = b;
                end else if (b == hsd_pkg::CH_STAR) begin
                  add_v = 1'b1;
                  leaf_v = 1'b0;
                end else if (b == hsd_pkg::CH_ESC) begin
                  esc_nxt = 1'b1;
                end else begin
                  add_v = 1'b1;
                  sym_v = b;
                end
                if (!add_v) begin
                  chk_v = 1'b1;
                  go_post = 1'b1;
                end else if (count_r >= hsd_pkg::NODE_CW'(hsd_pkg::NODE_DEPTH) ||
                             (count_r != '0 && level_r == '0)) begin
                  bad_v = 1'b1;
                  go_post = 1'b1;
                end else begin
                  node_we = 1'b1;
                  node_waddr = count_r[hsd_pkg::NODE_AW-1:0];
                  node_wdata.leaf = leaf_v;
                  node_wdata.sym = sym_v;
                  count_nxt = count_v;
                  add_idx_nxt = count_r[hsd_pkg::NODE_AW-1:0];
                  add_leaf_nxt = leaf_v;
                  if (level_r != '0) begin
                    // fetch the open parent from the top of the stack
                    stk_re = 1'b1;
                    stk_raddr = lvl_m1[hsd_pkg::STACK_AW-1:0];
                    state_nxt = hsd_pkg::S_STK;
                  end else begin
                    if (!leaf_v) begin
                      if (level_r >= hsd_pkg::STACK_LW'(hsd_pkg::STACK_DEPTH)) begin
                        bad_v = 1'b1;
                      end else begin
                        stk_we = 1'b1;
                        stk_waddr = level_r[hsd_pkg::STACK_AW-1:0];
                        stk_wdata = count_r[hsd_pkg::NODE_AW-1:0];
                        level_v = level_r + hsd_pkg::STACK_LW'(1);
                      end
                    end
                    level_nxt = level_v;
                    chk_v = 1'b1;
                    go_post = 1'b1;
                  end
                end
              end
              hsd_pkg::PH_DATA: begin
                byte_nxt = b;
                lo_nxt = in_ch.final_byte ? pad_r : 3'd0;
                bit_nxt = 3'd7;
                if (!cur_r.leaf) begin
                  node_re = 1'b1;
                  node_raddr = b[7] ? cur_r.right : cur_r.left;
                end
                state_nxt = hsd_pkg::S_WALK;
              end
              default: begin
                go_post = 1'b1;
              end
            endcase
          end
        end
      end

      hsd_pkg::S_STK: begin
        node_re = 1'b1;
        node_raddr = stk_rd_r;
        state_nxt = hsd_pkg::S_PAR;
      end

      hsd_pkg::S_PAR: begin
        // link the new node into its parent; a filled right side closes it
        node_we = 1'b1;
        node_waddr = stk_rd_r;
        node_wdata = p;
        if (p.left == '0) begin
          node_wdata.left = add_idx_r;
        end else begin
          node_wdata.right = add_idx_r;
          level_v = lvl_m1;
        end
        if (!add_leaf_r) begin
          if (level_v >= hsd_pkg::STACK_LW'(hsd_pkg::STACK_DEPTH)) begin
            bad_v = 1'b1;
          end else begin
            stk_we = 1'b1;
            stk_waddr = level_v[hsd_pkg::STACK_AW-1:0];
            stk_wdata = add_idx_r;
            level_v = level_v + hsd_pkg::STACK_LW'(1);
          end
        end
        level_nxt = level_v;
        chk_v = 1'b1;
        go_post = 1'b1;
      end

      hsd_pkg::S_WALK: begin
        res_ctl.res.symbol = cur_r.leaf ? cur_r.sym : node_rd_r.sym;
        if (!emit_v || res_sts.can_push) begin
          res_ctl.push = emit_v;
          cur_nxt = new_cur;
          if (bit_r == lo_r) begin
            go_post = 1'b1;
          end else begin
            bit_nxt = bit_v;
            if (!new_cur.leaf) begin
              node_re = 1'b1;
              node_raddr = byte_r[bit_v] ? new_cur.right : new_cur.left;
            end
          end
        end
      end

      hsd_pkg::S_POST: begin
        if (load_root_r) begin
          cur_nxt = root_r;
          load_root_nxt = 1'b0;
        end
        if (bad_r || trunc_r) begin
          res_ctl.push = 1'b1;
          res_ctl.res.status = hsd_pkg::RS_FAULT;
          if (res_sts.can_push) begin
            if (bad_r) begin
              bad_nxt = 1'b0;
            end else begin
              trunc_nxt = 1'b0;
            end
          end
        end else if (end_r) begin
          res_ctl.push = 1'b1;
          res_ctl.res.status = hsd_pkg::RS_END;
          if (res_sts.can_push) begin
            end_nxt = 1'b0;
            phase_nxt = hsd_pkg::PH_HDR1;
            pad_nxt = '0;
            tl_nxt = '0;
            esc_nxt = 1'b0;
            count_nxt = '0;
            level_nxt = '0;
            fault_nxt = 1'b0;
          end
        end else begin
          res_ctl.flush = 1'b1;
          if (res_sts.flush_ok) begin
            state_nxt = hsd_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = hsd_pkg::S_IDLE;
      end
    endcase

    // tree bytes used up: the tree must be closed to enter the payload
    if (chk_v && !bad_v && tl_nxt == '0) begin
      if (esc_nxt || level_nxt != '0 || count_nxt == '0) begin
        bad_v = 1'b1;
      end else begin
        phase_nxt = hsd_pkg::PH_DATA;
        load_root_nxt = 1'b1;
      end
    end

    if (go_post) begin
      state_nxt = hsd_pkg::S_POST;
      bad_nxt = bad_v;
      fault_nxt = fault_r || bad_v;
      end_nxt = fin_v;
      trunc_nxt = fin_v && !(fault_r || bad_v) && phase_nxt != hsd_pkg::PH_DATA;
    end
  end

  hsd_result_q u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_ctl (res_ctl),
    .res_sts (res_sts),
    .out_ch  (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= hsd_pkg::STACK_LW'(hsd_pkg::STACK_DEPTH))
    else $error("open-node stack level beyond its depth");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hsd_pkg::NODE_CW'(hsd_pkg::NODE_DEPTH))
    else $error("node count beyond node store depth");

  a_data_tree_closed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == hsd_pkg::PH_DATA |-> (count_r != '0 && level_r == '0 && !esc_r))
    else $error("payload phase with an unfinished tree");

  a_walk_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hsd_pkg::S_WALK |-> (phase_r == hsd_pkg::PH_DATA && !fault_r))
    else $error("tree walk outside the payload phase");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !fault_r) |=> state_r != hsd_pkg::S_IDLE)
    else $error("accepted byte left no work behind");
`endif

endmodule
